// File: hdl/qst_pkg.sv
// Shared types, constants and helpers for the query string tokenizer.
// Used by qst_scan, qst_result_fifo and query_string_tokenizer_top.
package qst_pkg;

  // Width of the position, offset and length counters.
  localparam int OFFSET_BITS = 16;
  // Width of the offset and length fields of a result item.
  localparam int FIELD_W     = 16;
  localparam int KIND_W      = 2;
  localparam int WIDE_W      = OFFSET_BITS + FIELD_W;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARAM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  // Special characters.
  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_SEMI = 8'h3b;
  localparam logic [7:0] CHAR_EQ   = 8'h3d;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_W-1:0]     field_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    field_t            key_start;
    field_t            key_len;
    field_t            value_start;
    field_t            value_len;
    logic              run_end;
  } qst_result_t;

  // Up to two result items produced by one input item.
  typedef struct packed {
    logic [1:0]  count;
    qst_result_t first;
    qst_result_t second;
  } qst_push_t;

  // Increment that sticks at the all-ones value.
  function automatic offset_t sat_inc(input offset_t v);
    offset_t res;
    if (v == {OFFSET_BITS{1'b1}}) begin
      res = v;
    end else begin
      res = v + offset_t'(1);
    end
    return res;
  endfunction

  // Resize a counter value to the result field width.
  function automatic field_t to_field(input offset_t v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// File: hdl/qst_scan.sv
// Per-byte tokenizer state and token decision logic.
// Depends on qst_pkg; feeds result items to qst_result_fifo.
module qst_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output qst_pkg::qst_push_t push
);
  import qst_pkg::*;

  logic    in_value_r, in_value_nxt;
  offset_t position_r, position_nxt;
  offset_t key_offset_r, key_offset_nxt;
  offset_t key_count_r, key_count_nxt;
  offset_t value_offset_r, value_offset_nxt;
  offset_t value_count_r, value_count_nxt;

  logic        is_sep;
  logic        is_eq;
  logic        tok_valid;
  qst_result_t tok;
  qst_result_t done_res;

  assign is_sep = (data_byte == CHAR_AMP) || (data_byte == CHAR_SEMI) ||
                  (data_byte == CHAR_NUL);
  assign is_eq  = (data_byte == CHAR_EQ);

  // Next state and the token, if any, that this byte produces.
  always_comb begin
    in_value_nxt     = in_value_r;
    position_nxt     = position_r;
    key_offset_nxt   = key_offset_r;
    key_count_nxt    = key_count_r;
    value_offset_nxt = value_offset_r;
    value_count_nxt  = value_count_r;
    tok_valid        = 1'b0;
    tok              = '0;

    if (!in_value_r) begin
      if (is_eq) begin
        in_value_nxt     = 1'b1;
        value_offset_nxt = sat_inc(position_r);
        value_count_nxt  = '0;
      end else if (is_sep) begin
        tok_valid        = (key_count_r != '0);
        tok.token_kind   = KIND_KEY;
        tok.key_start    = to_field(key_offset_r);
        tok.key_len      = to_field(key_count_r);
        key_offset_nxt   = sat_inc(position_r);
        key_count_nxt    = '0;
      end else begin
        key_count_nxt    = sat_inc(key_count_r);
      end
    end else begin
      if (is_sep || is_eq) begin
        tok_valid        = (key_count_r != '0);
        tok.token_kind   = KIND_PARAM;
        tok.key_start    = to_field(key_offset_r);
        tok.key_len      = to_field(key_count_r);
        tok.value_start  = to_field(value_offset_r);
        tok.value_len    = to_field(value_count_r);
        in_value_nxt     = 1'b0;
        key_offset_nxt   = sat_inc(position_r);
        key_count_nxt    = '0;
        value_offset_nxt = '0;
        value_count_nxt  = '0;
      end else begin
        value_count_nxt  = sat_inc(value_count_r);
      end
    end

    // On the final byte, flush any open token and return to the reset state.
    // A token ended by this byte leaves the key empty, so at most one applies.
    if (stream_end) begin
      if (key_count_nxt != '0) begin
        tok_valid      = 1'b1;
        tok            = '0;
        tok.key_start  = to_field(key_offset_nxt);
        tok.key_len    = to_field(key_count_nxt);
        if (in_value_nxt) begin
          tok.token_kind  = KIND_PARAM;
          tok.value_start = to_field(value_offset_nxt);
          tok.value_len   = to_field(value_count_nxt);
        end else begin
          tok.token_kind  = KIND_KEY;
        end
      end
      in_value_nxt     = 1'b0;
      position_nxt     = '0;
      key_offset_nxt   = '0;
      key_count_nxt    = '0;
      value_offset_nxt = '0;
      value_count_nxt  = '0;
    end else begin
      position_nxt = sat_inc(position_r);
    end
  end

  // Assemble the result items for the queue; the last one carries run_end.
  always_comb begin
    done_res            = '0;
    done_res.token_kind = KIND_DONE;
    done_res.run_end    = 1'b1;
    push                = '0;
    if (stream_end) begin
      if (tok_valid) begin
        push.count  = 2'd2;
        push.first  = tok;
        push.second = done_res;
      end else begin
        push.count  = 2'd1;
        push.first  = done_res;
      end
    end else if (tok_valid) begin
      push.count         = 2'd1;
      push.first         = tok;
      push.first.run_end = 1'b1;
    end
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  // State registers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r     <= 1'b0;
      position_r     <= '0;
      key_offset_r   <= '0;
      key_count_r    <= '0;
      value_offset_r <= '0;
      value_count_r  <= '0;
    end else if (fire) begin
      in_value_r     <= in_value_nxt;
      position_r     <= position_nxt;
      key_offset_r   <= key_offset_nxt;
      key_count_r    <= key_count_nxt;
      value_offset_r <= value_offset_nxt;
      value_count_r  <= value_count_nxt;
    end
  end

endmodule

// File: hdl/qst_result_fifo.sv
// Small result queue: takes up to two result items per cycle, gives one.
// Depends on qst_pkg.
module qst_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  qst_pkg::qst_push_t  push,
  input  logic                pop,
  output logic                not_empty,
  output logic                almost_full,
  output qst_pkg::qst_result_t head
);
  import qst_pkg::*;

  qst_result_t       mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  wr_ptr_p1;
  logic              do_pop;

  assign not_empty   = (count_r != '0);
  // Accept a new item only when two free slots are guaranteed.
  assign almost_full = (count_r > CNT_W'(QDEPTH - 2));
  assign head        = mem_r[rd_ptr_r];
  assign do_pop      = pop && not_empty;
  assign wr_ptr_p1   = wr_ptr_r + PTR_W'(1);

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

// File: hdl/query_string_tokenizer_top.sv
// Query string tokenizer: one byte per item in, KEY/PARAM/DONE tokens out.
// Each result item is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while in_stall is low; a byte that gives two items
// (token plus DONE) takes an extra output slot, absorbed by the four-entry result queue.
// Reset (rst_n low, synchronous) returns to key phase at offset 0, queue empty.
module query_string_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_kind,
  output logic [15:0] out_key_start,
  output logic [15:0] out_key_len,
  output logic [15:0] out_value_start,
  output logic [15:0] out_value_len,
  output logic        out_run_end
);
  import qst_pkg::*;

  logic        in_fire;
  logic        q_almost_full;
  qst_push_t   push;
  qst_result_t head;

  assign in_stall = q_almost_full;
  assign in_fire  = in_valid && !in_stall;

  // Token decision and counters.
  qst_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .push       (push)
  );

  // Result queue toward the output channel.
  qst_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop         (!out_stall),
    .not_empty   (out_valid),
    .almost_full (q_almost_full),
    .head        (head)
  );

  assign out_token_kind  = head.token_kind;
  assign out_key_start   = head.key_start;
  assign out_key_len     = head.key_len;
  assign out_value_start = head.value_start;
  assign out_value_len   = head.value_len;
  assign out_run_end     = head.run_end;

`ifndef SYNTH
  // A final byte always leaves at least its DONE item waiting.
  a_done_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_stream_end |=> out_valid)
    else $error("no result item after final byte");

  // DONE closes the run of its byte and carries no offsets.
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_DONE |->
      out_run_end && out_key_start == '0 && out_key_len == '0)
    else $error("malformed DONE item");

  // Only PARAM items carry a value.
  a_value_only_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_PARAM |->
      out_value_start == '0 && out_value_len == '0)
    else $error("value fields set on non-PARAM item");

  // KEY and PARAM items never have an empty key.
  a_key_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_KEY || out_token_kind == KIND_PARAM) |->
      out_key_len != '0)
    else $error("token with empty key emitted");
`endif

endmodule
